// File: rtl/rsh_pkg.sv
package rsh_pkg;

   // Frame geometry
   localparam int IMAGE_WIDTH  = 320;
   localparam int IMAGE_HEIGHT = 240;
   localparam int TOTAL_PIXELS = IMAGE_WIDTH * IMAGE_HEIGHT;
   // Last item position of a frame: all pixels plus one row and one pixel of flush
   localparam int POS_MAX      = TOTAL_PIXELS + IMAGE_WIDTH;

   localparam int COL_W = $clog2(IMAGE_WIDTH);
   localparam int ROW_W = $clog2(IMAGE_HEIGHT);
   localparam int POS_W = $clog2(POS_MAX + 1);

   // Sample and arithmetic widths
   localparam int CHANNELS = 3;
   localparam int PIX_W    = 8;
   localparam int STR_W    = 4;
   localparam int SUM_W    = PIX_W + 3;
   localparam int PC_W     = PIX_W + STR_W + 1;
   localparam int PS_W     = SUM_W + STR_W;
   localparam int ACC_W    = PC_W + 4;

   localparam logic [STR_W-1:0] STRENGTH_RESET = STR_W'(4);

   // Item kinds carried on tuser
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   // One RGB pixel, red in the lowest byte
   typedef logic [CHANNELS-1:0][PIX_W-1:0] pixel_type;
   typedef logic [COL_W-1:0] col_type;
   typedef logic [8:0][PIX_W-1:0] chan_win_type;

   // Stage load strobes for the per-channel lanes
   typedef struct packed {
      logic load_sum;
      logic load_prod;
   } lane_ctrl_type;

endpackage

// File: rtl/rsh_line_buf.sv
module rsh_line_buf (
   input  logic                clock,
   input  logic                rd_en,
   input  rsh_pkg::col_type    rd_addr,
   output rsh_pkg::pixel_type  rd_data,
   input  logic                wr_en,
   input  rsh_pkg::col_type    wr_addr,
   input  rsh_pkg::pixel_type  wr_data
);

   rsh_pkg::pixel_type mem_ff [rsh_pkg::IMAGE_WIDTH];
   rsh_pkg::pixel_type rd_data_ff;

   // Read old data first, then write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/rsh_lane.sv
module rsh_lane (
   input  logic                          clock,
   input  rsh_pkg::lane_ctrl_type        ctrl,
   input  logic [rsh_pkg::STR_W-1:0]     strength,
   input  rsh_pkg::chan_win_type         win,
   output logic [rsh_pkg::PIX_W-1:0]     result
);

   logic [rsh_pkg::SUM_W-1:0]        sum_in;
   logic [rsh_pkg::SUM_W-1:0]        sum_ff;
   logic [rsh_pkg::PIX_W-1:0]        center_ff;
   logic [rsh_pkg::STR_W:0]          center_wt;
   logic [rsh_pkg::PC_W-1:0]         pc_in;
   logic [rsh_pkg::PC_W-1:0]         pc_ff;
   logic [rsh_pkg::PS_W-1:0]         ps_in;
   logic [rsh_pkg::PS_W-1:0]         ps_ff;
   logic signed [rsh_pkg::ACC_W-1:0] acc;

   // Add the eight neighbors
   always_comb begin
      sum_in = '0;
      for (int i = 0; i < 9; i++) begin
         if (i != 4) begin
            sum_in = sum_in + rsh_pkg::SUM_W'(win[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_sum) begin
         sum_ff    <= sum_in;
         center_ff <= win[4];
      end
   end

   // Center weight strength+1 and neighbor weight strength, in eighths later
   assign center_wt = {1'b0, strength} + (rsh_pkg::STR_W + 1)'(1);
   assign pc_in     = rsh_pkg::PC_W'(center_wt) * rsh_pkg::PC_W'(center_ff);
   assign ps_in     = rsh_pkg::PS_W'(strength) * rsh_pkg::PS_W'(sum_ff);

   always_ff @(posedge clock) begin
      if (ctrl.load_prod) begin
         pc_ff <= pc_in;
         ps_ff <= ps_in;
      end
   end

   // Subtract, drop negatives, scale down by eight and saturate
   assign acc = $signed({1'b0, pc_ff, 3'b000}) - $signed(rsh_pkg::ACC_W'(ps_ff));

   always_comb begin
      if (acc[rsh_pkg::ACC_W-1]) begin
         result = '0;
      end else if (acc[rsh_pkg::ACC_W-2:3] > (rsh_pkg::ACC_W-4)'(255)) begin
         result = '1;
      end else begin
         result = acc[rsh_pkg::PIX_W+2:3];
      end
   end

endmodule

// File: rtl/rgb_sharpen_3x3_filter.sv
// RGB 3x3 sharpening filter for a raster stream of IMAGE_WIDTH x IMAGE_HEIGHT
// pixels. Each accepted request yields the pixel one row plus one pixel
// earlier, so the first IMAGE_WIDTH+1 requests of a frame give no response;
// after the last pixel send IMAGE_WIDTH+1 flush requests (tuser = 1) to drain
// the frame, and the final response carries tlast. Flush requests sent before
// the frame is complete are taken and dropped. Interior pixels get
// (strength+1)*center - strength/8*(sum of neighbors), clamped to 0..255;
// border pixels pass through. One request is taken every clock while the
// response side is not stalling: both line stores are single-port-per-side
// RAMs read and written once per pixel, and the three color lanes run in
// parallel through a five-stage pipeline. Write strength only while the
// block is idle.
module rgb_sharpen_3x3_filter (
   input  logic        clock,
   input  logic        reset,
   // Request: tdata = red[7:0], green[15:8], blue[23:16]; tuser = kind
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic        req_tuser,
   // Response: tdata = red[7:0], green[15:8], blue[23:16]; tlast = frame end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast,
   // Strength register
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data
);

   localparam int W = rsh_pkg::IMAGE_WIDTH;
   localparam int H = rsh_pkg::IMAGE_HEIGHT;

   logic [rsh_pkg::STR_W-1:0] strength_ff;

   // Frame position counters
   logic [rsh_pkg::POS_W-1:0] pos_ff, pos_in;
   rsh_pkg::col_type          col_ff, col_in;
   rsh_pkg::col_type          ocol_ff, ocol_in;
   logic [rsh_pkg::ROW_W-1:0] orow_ff, orow_in;

   // Pipeline control
   logic accept, ignored, frame_full, has_result, interior, last;
   logic ld1, ld2, ld3, ld4, ld5;
   logic free1, free2, free3, free4, free5;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;

   // Stage payloads
   rsh_pkg::pixel_type px_in, s1_px_ff, rd_mid, rd_top;
   rsh_pkg::col_type   s1_col_ff;
   logic               s1_hr_ff, s1_int_ff, s1_last_ff;
   logic               s2_int_ff, s2_last_ff;
   logic               s3_int_ff, s3_last_ff, s4_int_ff, s4_last_ff;
   rsh_pkg::pixel_type s3_center_ff, s4_center_ff;
   rsh_pkg::pixel_type win_ff [3][3];
   rsh_pkg::chan_win_type chan_win [rsh_pkg::CHANNELS];
   rsh_pkg::pixel_type lane_px;
   rsh_pkg::lane_ctrl_type lane_ctrl;
   logic [23:0] rsp_data_ff;
   logic        rsp_last_ff;

   // Strength register
   always_ff @(posedge clock) begin
      if (reset) begin
         strength_ff <= rsh_pkg::STRENGTH_RESET;
      end else if (csr_wr_en) begin
         strength_ff <= csr_wr_data;
      end
   end

   // Ready chain: a stage frees up when empty or when it moves on
   assign free5 = !v5_ff || rsp_tready;
   assign free4 = !v4_ff || free5;
   assign free3 = !v3_ff || free4;
   assign free2 = !v2_ff || free3;
   assign free1 = !v1_ff || free2;
   assign ld2   = v1_ff && free2;
   assign ld3   = v2_ff && free3;
   assign ld4   = v3_ff && free4;
   assign ld5   = v4_ff && free5;

   assign req_tready = free1;
   assign accept     = req_tvalid && free1;
   assign frame_full = pos_ff >= rsh_pkg::POS_W'(rsh_pkg::TOTAL_PIXELS);
   assign ignored    = (req_tuser == rsh_pkg::KIND_FLUSH) && !frame_full;
   assign ld1        = accept && !ignored;
   assign px_in      = frame_full ? '0 : rsh_pkg::pixel_type'(req_tdata);

   // Classify the output position of this request
   assign has_result = pos_ff > rsh_pkg::POS_W'(W);
   assign interior   = (orow_ff != '0) && (orow_ff < rsh_pkg::ROW_W'(H - 1))
                    && (ocol_ff != '0) && (ocol_ff < rsh_pkg::COL_W'(W - 1));
   assign last       = has_result && (orow_ff == rsh_pkg::ROW_W'(H - 1))
                    && (ocol_ff == rsh_pkg::COL_W'(W - 1));

   // Advance position counters, wrap at frame end
   always_comb begin
      pos_in  = pos_ff;
      col_in  = col_ff;
      ocol_in = ocol_ff;
      orow_in = orow_ff;
      if (ld1) begin
         if (last) begin
            pos_in  = '0;
            col_in  = '0;
            ocol_in = '0;
            orow_in = '0;
         end else begin
            pos_in = pos_ff + rsh_pkg::POS_W'(1);
            col_in = (col_ff == rsh_pkg::COL_W'(W - 1)) ? '0 : col_ff + rsh_pkg::COL_W'(1);
            if (has_result) begin
               if (ocol_ff == rsh_pkg::COL_W'(W - 1)) begin
                  ocol_in = '0;
                  orow_in = orow_ff + rsh_pkg::ROW_W'(1);
               end else begin
                  ocol_in = ocol_ff + rsh_pkg::COL_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         col_ff  <= '0;
         ocol_ff <= '0;
         orow_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         col_ff  <= col_in;
         ocol_ff <= ocol_in;
         orow_ff <= orow_in;
      end
   end

   // Line stores: previous row and the row before it
   rsh_line_buf u_line_mid (
      .clock   (clock),
      .rd_en   (ld1),
      .rd_addr (col_ff),
      .rd_data (rd_mid),
      .wr_en   (ld1),
      .wr_addr (col_ff),
      .wr_data (px_in)
   );

   rsh_line_buf u_line_top (
      .clock   (clock),
      .rd_en   (ld1),
      .rd_addr (col_ff),
      .rd_data (rd_top),
      .wr_en   (ld2),
      .wr_addr (s1_col_ff),
      .wr_data (rd_mid)
   );

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= ld1 ? 1'b1 : (free1 ? 1'b0 : v1_ff);
         v2_ff <= (ld2 && s1_hr_ff) ? 1'b1 : (free2 ? 1'b0 : v2_ff);
         v3_ff <= ld3 ? 1'b1 : (free3 ? 1'b0 : v3_ff);
         v4_ff <= ld4 ? 1'b1 : (free4 ? 1'b0 : v4_ff);
         v5_ff <= ld5 ? 1'b1 : (free5 ? 1'b0 : v5_ff);
      end
   end

   // Stage 1: hold pixel and flags while the line stores are read
   always_ff @(posedge clock) begin
      if (ld1) begin
         s1_px_ff   <= px_in;
         s1_col_ff  <= col_ff;
         s1_hr_ff   <= has_result;
         s1_int_ff  <= interior;
         s1_last_ff <= last;
      end
   end

   // Stage 2: shift the window left and load the new column
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else if (ld2) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= rd_top;
         win_ff[1][2] <= rd_mid;
         win_ff[2][2] <= s1_px_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld2) begin
         s2_int_ff  <= s1_int_ff;
         s2_last_ff <= s1_last_ff;
      end
   end

   // Split the window into one view per color
   always_comb begin
      for (int ch = 0; ch < rsh_pkg::CHANNELS; ch++) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               chan_win[ch][r*3 + c] = win_ff[r][c][ch];
            end
         end
      end
   end

   assign lane_ctrl.load_sum  = ld3;
   assign lane_ctrl.load_prod = ld4;

   // Color lanes
   for (genvar g = 0; g < rsh_pkg::CHANNELS; g++) begin : g_lane
      rsh_lane u_lane (
         .clock    (clock),
         .ctrl     (lane_ctrl),
         .strength (strength_ff),
         .win      (chan_win[g]),
         .result   (lane_px[g])
      );
   end

   // Stages 3 and 4: carry center and flags beside the lanes
   always_ff @(posedge clock) begin
      if (ld3) begin
         s3_center_ff <= win_ff[1][1];
         s3_int_ff    <= s2_int_ff;
         s3_last_ff   <= s2_last_ff;
      end
      if (ld4) begin
         s4_center_ff <= s3_center_ff;
         s4_int_ff    <= s3_int_ff;
         s4_last_ff   <= s3_last_ff;
      end
   end

   // Stage 5: merge lanes or pass the border pixel through
   always_ff @(posedge clock) begin
      if (ld5) begin
         rsp_data_ff <= s4_int_ff ? 24'(lane_px) : 24'(s4_center_ff);
         rsp_last_ff <= s4_last_ff;
      end
   end

   assign rsp_tvalid = v5_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Position stays within one frame plus its flush
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= rsh_pkg::POS_W'(rsh_pkg::POS_MAX))
      else $error("position counter past end of frame");

   // Column counters stay inside the row, output row inside the frame
   a_coord_range: assert property (@(posedge clock) disable iff (reset)
      (col_ff < rsh_pkg::COL_W'(W)) && (ocol_ff < rsh_pkg::COL_W'(W))
      && (orow_ff < rsh_pkg::ROW_W'(H)))
      else $error("coordinate counter out of range");

   // A new frame starts with all coordinate counters at the origin
   a_frame_start: assert property (@(posedge clock) disable iff (reset)
      (pos_ff == '0) |-> (col_ff == '0 && ocol_ff == '0 && orow_ff == '0))
      else $error("counters out of step at frame start");

   // A frame end leaves the position counter at zero
   a_last_wrap: assert property (@(posedge clock) disable iff (reset)
      (ld1 && last) |=> (pos_ff == '0))
      else $error("position not cleared after frame end");

endmodule

// File: tb/sv/rgb_sharpen_checker.sv
module rgb_sharpen_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [23:0]       req_tdata,
   input  logic              req_tuser,
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [23:0]       rsp_tdata,
   input  logic              rsp_tlast,
   input  logic              csr_wr_en,
   input  logic [3:0]        csr_wr_data,
   output int unsigned       mismatch_count,
   output int unsigned       pending_count
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned REPORT_LIMIT = 10;

   typedef struct packed {
      logic               frame_end;
      rsh_pkg::pixel_type pix;
   } out_pixel_type;

   // Predictor state: gain, line stores, 3x3 window and item position in the frame
   logic [3:0]         gain;
   rsh_pkg::pixel_type prev_row  [rsh_pkg::IMAGE_WIDTH];
   rsh_pkg::pixel_type prev2_row [rsh_pkg::IMAGE_WIDTH];
   rsh_pkg::pixel_type win       [9];
   int unsigned        item_pos;

   out_pixel_type sharpened_q [$];
   out_pixel_type fresh;
   out_pixel_type oldest;
   int unsigned   fail_total = 0;
   int unsigned   rsp_index  = 0;

   // Sharpen one color lane of the window center, clamped to 0..255
   function automatic logic [7:0] sharpen_lane(input int ch);
      int g;
      int center;
      int ring_sum;
      int acc;
      g        = int'(gain);
      center   = int'(win[4][ch]);
      ring_sum = 0;
      for (int i = 0; i < 9; i++) begin
         if (i != 4) ring_sum += int'(win[i][ch]);
      end
      acc = (8 * g + 8) * center - g * ring_sum;
      if (acc < 0) return 8'd0;
      acc = acc / 8;
      if (acc > 255) acc = 255;
      return 8'(acc);
   endfunction

   // Advance the window by one accepted request; return 1 when it yields a pixel
   function automatic bit filter_request(input logic kind, input rsh_pkg::pixel_type pix_in,
                                         output out_pixel_type res);
      rsh_pkg::pixel_type fed;
      rsh_pkg::pixel_type above;
      rsh_pkg::pixel_type mid;
      int unsigned        col;
      int unsigned        q;
      int unsigned        r;
      int unsigned        c;
      bit                 interior;
      bit                 at_end;
      res = '0;
      // Drop flush requests while the frame is still arriving
      if (kind == rsh_pkg::KIND_FLUSH && item_pos < rsh_pkg::TOTAL_PIXELS) return 1'b0;
      fed   = (item_pos < rsh_pkg::TOTAL_PIXELS) ? pix_in : rsh_pkg::pixel_type'('0);
      col   = item_pos % rsh_pkg::IMAGE_WIDTH;
      above = prev2_row[col];
      mid   = prev_row[col];
      prev2_row[col] = mid;
      prev_row[col]  = fed;
      for (int k = 0; k < 3; k++) begin
         win[k*3]     = win[k*3 + 1];
         win[k*3 + 1] = win[k*3 + 2];
      end
      win[2] = above;
      win[5] = mid;
      win[8] = fed;
      // Nothing comes out until one row plus one pixel is buffered
      if (item_pos < rsh_pkg::IMAGE_WIDTH + 1) begin
         item_pos++;
         return 1'b0;
      end
      q        = item_pos - rsh_pkg::IMAGE_WIDTH - 1;
      r        = q / rsh_pkg::IMAGE_WIDTH;
      c        = q % rsh_pkg::IMAGE_WIDTH;
      interior = (r >= 1) && (r + 2 <= rsh_pkg::IMAGE_HEIGHT)
              && (c >= 1) && (c + 2 <= rsh_pkg::IMAGE_WIDTH);
      at_end   = (q + 1 == rsh_pkg::TOTAL_PIXELS);
      if (interior) begin
         for (int ch = 0; ch < rsh_pkg::CHANNELS; ch++) res.pix[ch] = sharpen_lane(ch);
      end else begin
         res.pix = win[4];
      end
      res.frame_end = at_end;
      item_pos = at_end ? 0 : item_pos + 1;
      return 1'b1;
   endfunction

   // Track config writes and requests, compare every response with the oldest prediction
   always @(posedge clock) begin : track
      if (reset) begin
         gain      = rsh_pkg::STRENGTH_RESET;
         item_pos  = 0;
         win       = '{default: '0};
         prev_row  = '{default: '0};
         prev2_row = '{default: '0};
         sharpened_q.delete();
      end else begin
         if (csr_wr_en) gain = csr_wr_data;
         if (req_tvalid && req_tready) begin
            if (filter_request(req_tuser, req_tdata, fresh)) sharpened_q.push_back(fresh);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (sharpened_q.size() == 0) begin
               fail_total++;
               if (fail_total <= REPORT_LIMIT)
                  $display("response %0d with no pixel expected: tdata %h tlast %b",
                           rsp_index, rsp_tdata, rsp_tlast);
            end else begin
               oldest = sharpened_q.pop_front();
               if (rsp_tdata[7:0] !== oldest.pix[0] || rsp_tdata[15:8] !== oldest.pix[1] ||
                   rsp_tdata[23:16] !== oldest.pix[2] || rsp_tlast !== oldest.frame_end) begin
                  fail_total++;
                  if (fail_total <= REPORT_LIMIT)
                     $display({"response %0d: expected r %0d g %0d b %0d last %b,",
                               " got r %0d g %0d b %0d last %b"},
                              rsp_index, oldest.pix[0], oldest.pix[1], oldest.pix[2],
                              oldest.frame_end, rsp_tdata[7:0], rsp_tdata[15:8],
                              rsp_tdata[23:16], rsp_tlast);
               end
            end
            rsp_index++;
         end
      end
      pending_count  <= sharpened_q.size();
      mismatch_count <= fail_total;
   end

endmodule

// File: tb/sv/tb_rgb_sharpen_3x3_filter.sv
module tb_rgb_sharpen_3x3_filter;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned IDLE_LIMIT    = 5000;
   localparam int unsigned SETTLE_CYCLES = 10;
   localparam int unsigned TAIL_CYCLES   = 20;
   localparam int unsigned HOLD_AFTER    = 150;
   localparam int unsigned HOLD_CYCLES   = 400;
   localparam int unsigned FRAME_PIXELS  = 1120;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata   = '0;
   logic        req_tuser   = rsh_pkg::KIND_PIXEL;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_wr_en   = 1'b0;
   logic [3:0]  csr_wr_data = '0;

   int unsigned mismatch_count;
   int unsigned pending_count;
   int unsigned stall_cycles = 0;
   int unsigned burst_left   = 0;
   logic [23:0] last_pix     = 24'h808080;

   rgb_sharpen_3x3_filter i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   rgb_sharpen_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Abort when neither side moves for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
         stall_cycles <= 0;
      end else if (stall_cycles == IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Receiver: phases of random readiness, plus one long hold-off to back up the pipeline
   initial begin : rsp_side
      int unsigned taken;
      int unsigned phase_left;
      int unsigned ready_pct;
      bit          held;
      taken      = 0;
      phase_left = 0;
      ready_pct  = 100;
      held       = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) taken++;
         if (!held && taken >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (phase_left == 0) begin
            case ($urandom_range(0, 3))
               0: ready_pct = 100;
               1: ready_pct = 75;
               2: ready_pct = 50;
               default: ready_pct = 20;
            endcase
            phase_left = $urandom_range(5, 60);
         end
         phase_left--;
         rsp_tready <= ($urandom_range(0, 99) < ready_pct);
      end
   end

   // Start a new burst with a random gap in front when the current one runs out
   task automatic pace_sender();
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(500, 1500)
                                                  : $urandom_range(1, 48);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   // Offer one request and hold it until it is taken
   task automatic send_req(input logic kind, input logic [23:0] data);
      pace_sender();
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
   endtask

   // Drain every pending pixel, let the pipeline settle, then write the gain
   task automatic write_strength(input logic [3:0] value);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Mix of flat black, white, noise and smooth gradients so both clamps and mid values occur
   function automatic logic [23:0] random_pixel();
      logic [23:0] pix;
      int          v;
      case ($urandom_range(0, 9))
         0: pix = '0;
         1: pix = '1;
         2, 3, 4: pix = 24'($urandom());
         default: begin
            for (int ch = 0; ch < rsh_pkg::CHANNELS; ch++) begin
               v = int'(last_pix[ch*8 +: 8]) + int'($urandom_range(0, 16)) - 8;
               if (v < 0) v = 0;
               if (v > 255) v = 255;
               pix[ch*8 +: 8] = 8'(v);
            end
         end
      endcase
      last_pix = pix;
      return pix;
   endfunction

   // Stream pixels of a frame, with stray flush requests mixed in that must be dropped
   task automatic stream_pixels(input int unsigned from_pos, input int unsigned to_pos);
      for (int unsigned p = from_pos; p < to_pos; p++) begin
         if ($urandom_range(0, 63) == 0) send_req(rsh_pkg::KIND_FLUSH, 24'($urandom()));
         send_req(rsh_pkg::KIND_PIXEL, random_pixel());
      end
   endtask

   initial begin : req_side
      logic [23:0] edge_pixels [12];
      int unsigned cut [6];
      logic [3:0]  gain_at_cut [6];
      int unsigned start;
      edge_pixels = '{24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFF0000,
                      24'h555555, 24'hAAAAAA, 24'h010101, 24'h808080, 24'h7F7F7F,
                      24'hFEFEFE, 24'h000000};
      cut         = '{400, 520, 640, 760, 880, 1000};
      gain_at_cut = '{4'd15, 4'd0, 4'd1, 4'd8, 4'($urandom_range(0, 15)), 4'd15};

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Start of a frame at the reset gain: stray flush up front, extreme samples on top row
      send_req(rsh_pkg::KIND_FLUSH, 24'hFFFFFF);
      foreach (edge_pixels[i]) send_req(rsh_pkg::KIND_PIXEL, edge_pixels[i]);
      start = 12;
      for (int i = 0; i < 6; i++) begin
         stream_pixels(start, cut[i]);
         write_strength(gain_at_cut[i]);
         start = cut[i];
      end
      stream_pixels(start, FRAME_PIXELS);

      // Wait for the last pixels, then give stragglers time to show up
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
